### sv/two_level_device_number_allocator_assert.svh
`ifndef TWO_LEVEL_DEVICE_NUMBER_ALLOCATOR_ASSERT_SVH
`define TWO_LEVEL_DEVICE_NUMBER_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define TLDNA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tldna assertion failed");

// Next-cycle implication.
`define TLDNA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tldna assertion failed");

`endif

### sv/tldna_pkg.sv
`timescale 1ns / 1ps

package tldna_pkg;

  localparam int NUM_W         = 8;
  localparam int WORD_W        = 64;
  localparam int BIT_W         = 6;
  localparam int WORDS_PER_ROW = 4;
  localparam int WIDX_W        = 2;
  localparam int MAP_DEPTH     = 1024;
  localparam int ROW_ADDR_W    = 10;
  localparam int CNT_DEPTH     = 256;
  localparam int CNT_W         = 8;
  localparam int IN_DATA_W     = 16;
  localparam int OUT_DATA_W    = 24;

  localparam logic [NUM_W-1:0] MISC_MAJOR = 8'd10;
  localparam logic [NUM_W-1:0] TOP_NUMBER = 8'd255;
  localparam logic [CNT_W-1:0] CNT_MAX    = 8'd255;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_BAD_PARAM  = 3'd1,
    STAT_NONE_FREE  = 3'd2,
    STAT_BUSY       = 3'd3,
    STAT_NOT_IN_USE = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MAJ_SCAN,
    S_ISSUE,
    S_EVAL,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic scan;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_bad;
    logic req_dyn_major;
    logic scan_found;
    logic scan_last;
    logic eval_next;
    logic out_free;
  } sts_t;

  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [WORD_W-1:0] major_reset_word(input logic [WIDX_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = '0;
    if (w == '0) v[0] = 1'b1;
    if (MISC_MAJOR[NUM_W-1:BIT_W] == w) v[MISC_MAJOR[BIT_W-1:0]] = 1'b1;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] minor_reset_word(input logic [WIDX_W-1:0] w);
    logic [WORD_W-1:0] v;
    v = '0;
    if (w == WIDX_W'(WORDS_PER_ROW - 1)) v[WORD_W-1] = 1'b1;
    return v;
  endfunction

endpackage

### sv/tldna_ram.sv
`timescale 1ns / 1ps

module tldna_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tldna_ctrl.sv
`timescale 1ns / 1ps

module tldna_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  tldna_pkg::sts_t sts,
  output logic            in_ready,
  output tldna_pkg::cmd_t cmd
);

  tldna_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tldna_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tldna_pkg::S_CLEAR: begin
        if (sts.clear_done) state_next = tldna_pkg::S_IDLE;
      end
      tldna_pkg::S_IDLE: begin
        if (in_valid) begin
          if (sts.req_bad) state_next = tldna_pkg::S_RESULT;
          else if (sts.req_dyn_major) state_next = tldna_pkg::S_MAJ_SCAN;
          else state_next = tldna_pkg::S_ISSUE;
        end
      end
      tldna_pkg::S_MAJ_SCAN: begin
        if (sts.scan_found) state_next = tldna_pkg::S_ISSUE;
        else if (sts.scan_last) state_next = tldna_pkg::S_RESULT;
      end
      tldna_pkg::S_ISSUE: begin
        state_next = tldna_pkg::S_EVAL;
      end
      tldna_pkg::S_EVAL: begin
        if (sts.eval_next) state_next = tldna_pkg::S_ISSUE;
        else state_next = tldna_pkg::S_RESULT;
      end
      tldna_pkg::S_RESULT: begin
        if (sts.out_free) state_next = tldna_pkg::S_IDLE;
      end
      default: begin
        state_next = tldna_pkg::S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      tldna_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      tldna_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tldna_pkg::S_MAJ_SCAN: begin
        cmd.scan = 1'b1;
      end
      tldna_pkg::S_ISSUE: begin
        cmd = '0;
      end
      tldna_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
      end
      tldna_pkg::S_RESULT: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### sv/tldna_dp.sv
`timescale 1ns / 1ps

module tldna_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  tldna_pkg::cmd_t                   cmd,
  output tldna_pkg::sts_t                   sts,
  input  logic                              in_op,
  input  logic [tldna_pkg::NUM_W-1:0]       in_major,
  input  logic [tldna_pkg::NUM_W-1:0]       in_minor,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tldna_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int NW = tldna_pkg::NUM_W;
  localparam int WW = tldna_pkg::WORD_W;
  localparam int XW = tldna_pkg::WIDX_W;
  localparam int CW = tldna_pkg::CNT_W;
  localparam int AW = tldna_pkg::ROW_ADDR_W;
  localparam logic [XW-1:0] LAST_WORD = XW'(tldna_pkg::WORDS_PER_ROW - 1);

  tldna_pkg::op_t     op;
  logic [NW-1:0]      maj;
  logic [NW-1:0]      mi;
  logic [XW-1:0]      widx;
  logic               dyn_minor;
  tldna_pkg::status_t res_status;
  logic [NW-1:0]      res_major;
  logic [NW-1:0]      res_minor;
  tldna_pkg::status_t out_status;
  logic [NW-1:0]      out_major;
  logic [NW-1:0]      out_minor;
  logic [WW-1:0]      major_map [tldna_pkg::WORDS_PER_ROW];
  logic [AW-1:0]      clr_cnt;

  logic               req_alloc;
  logic [WW-1:0]      scan_free;
  logic [tldna_pkg::BIT_W-1:0] scan_hi;

  logic               map_we;
  logic [AW-1:0]      map_waddr;
  logic [WW-1:0]      map_wdata;
  logic [WW-1:0]      rd_word;
  logic               cnt_we;
  logic [NW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic [CW-1:0]      rd_cnt;

  logic [WW-1:0]      dyn_free;
  logic               dyn_found;
  logic [tldna_pkg::BIT_W-1:0] dyn_lo;
  logic [tldna_pkg::BIT_W-1:0] bit_sel;
  logic [WW-1:0]      bit_mask;
  logic               bit_used;
  logic               eval_ok;
  tldna_pkg::status_t eval_fail;
  logic [WW-1:0]      new_word;
  logic [CW-1:0]      cnt_next;
  logic [NW-1:0]      mi_final;

  // request decode
  assign req_alloc         = (tldna_pkg::op_t'(in_op) == tldna_pkg::OP_ALLOC);
  assign sts.req_dyn_major = req_alloc && (in_major == '0);
  assign sts.req_bad       = (req_alloc && (in_major == '0) && (in_minor != '0)) ||
                             (!req_alloc && ((in_major == '0) ||
                                             (in_minor == tldna_pkg::TOP_NUMBER)));
  assign sts.clear_done    = (clr_cnt == AW'(tldna_pkg::MAP_DEPTH - 1));
  assign sts.out_free      = !out_valid || out_ready;

  // major scan, top word first; major 0 never free
  assign scan_free      = ~major_map[widx] & ~((widx == '0) ? WW'(1) : '0);
  assign scan_hi        = tldna_pkg::highest_set(scan_free);
  assign sts.scan_found = |scan_free;
  assign sts.scan_last  = (widx == '0);

  // minor word evaluation; top minor stays reserved
  assign dyn_free  = ~rd_word & ~((widx == LAST_WORD) ? {1'b1, {(WW - 1){1'b0}}} : '0);
  assign dyn_found = |dyn_free;
  assign dyn_lo    = tldna_pkg::lowest_set(dyn_free);
  assign bit_sel   = dyn_minor ? dyn_lo : mi[tldna_pkg::BIT_W-1:0];
  assign bit_mask  = WW'(1) << bit_sel;
  assign bit_used  = rd_word[bit_sel];
  assign sts.eval_next = dyn_minor && !dyn_found && (widx != LAST_WORD);

  always_comb begin
    if (dyn_minor) begin
      eval_ok   = dyn_found;
      eval_fail = tldna_pkg::STAT_NONE_FREE;
    end else if (op == tldna_pkg::OP_ALLOC) begin
      eval_ok   = !bit_used;
      eval_fail = tldna_pkg::STAT_BUSY;
    end else begin
      eval_ok   = bit_used;
      eval_fail = tldna_pkg::STAT_NOT_IN_USE;
    end
  end

  always_comb begin
    if (op == tldna_pkg::OP_ALLOC) begin
      new_word = rd_word | bit_mask;
      cnt_next = (rd_cnt != tldna_pkg::CNT_MAX) ? rd_cnt + CW'(1) : rd_cnt;
    end else begin
      new_word = rd_word & ~bit_mask;
      cnt_next = (rd_cnt != '0) ? rd_cnt - CW'(1) : rd_cnt;
    end
  end

  assign mi_final = dyn_minor ? {widx, dyn_lo} : mi;

  // memory ports
  assign map_we    = cmd.clear_step || (cmd.eval && eval_ok);
  assign map_waddr = cmd.clear_step ? clr_cnt : {maj, widx};
  assign map_wdata = cmd.clear_step ? tldna_pkg::minor_reset_word(clr_cnt[XW-1:0]) : new_word;
  assign cnt_we    = map_we;
  assign cnt_waddr = cmd.clear_step ? clr_cnt[NW-1:0] : maj;
  assign cnt_wdata = cmd.clear_step ? '0 : cnt_next;

  tldna_ram #(
    .WIDTH (WW),
    .DEPTH (tldna_pkg::MAP_DEPTH)
  ) u_minor_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr ({maj, widx}),
    .rdata (rd_word)
  );

  tldna_ram #(
    .WIDTH (CW),
    .DEPTH (tldna_pkg::CNT_DEPTH)
  ) u_minor_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (maj),
    .rdata (rd_cnt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      clr_cnt   <= '0;
      for (int w = 0; w < tldna_pkg::WORDS_PER_ROW; w++) begin
        major_map[w] <= tldna_pkg::major_reset_word(XW'(w));
      end
    end else begin
      if (cmd.clear_step) clr_cnt <= clr_cnt + AW'(1);
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (cmd.eval && eval_ok) begin
        if (op == tldna_pkg::OP_ALLOC) begin
          major_map[maj[NW-1:tldna_pkg::BIT_W]][maj[tldna_pkg::BIT_W-1:0]] <= 1'b1;
        end else if ((maj != tldna_pkg::MISC_MAJOR) && (cnt_next == '0)) begin
          major_map[maj[NW-1:tldna_pkg::BIT_W]][maj[tldna_pkg::BIT_W-1:0]] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= tldna_pkg::op_t'(in_op);
      maj       <= in_major;
      mi        <= in_minor;
      dyn_minor <= req_alloc && (in_minor == tldna_pkg::TOP_NUMBER);
      if (sts.req_dyn_major) widx <= LAST_WORD;
      else if (req_alloc && (in_minor == tldna_pkg::TOP_NUMBER)) widx <= '0;
      else widx <= in_minor[NW-1:tldna_pkg::BIT_W];
      res_status <= tldna_pkg::STAT_BAD_PARAM;
      res_major  <= '0;
      res_minor  <= '0;
    end
    if (cmd.scan) begin
      if (sts.scan_found) begin
        maj  <= {widx, scan_hi};
        widx <= '0;
      end else if (sts.scan_last) begin
        res_status <= tldna_pkg::STAT_NONE_FREE;
        res_major  <= '0;
        res_minor  <= '0;
      end else begin
        widx <= widx - XW'(1);
      end
    end
    if (cmd.eval) begin
      if (eval_ok) begin
        res_status <= tldna_pkg::STAT_OK;
        res_major  <= maj;
        res_minor  <= mi_final;
      end else if (sts.eval_next) begin
        widx <= widx + XW'(1);
      end else begin
        res_status <= eval_fail;
        res_major  <= '0;
        res_minor  <= '0;
      end
    end
    if (cmd.load_out) begin
      out_status <= res_status;
      out_major  <= res_major;
      out_minor  <= res_minor;
    end
  end

  assign out_data = {{(tldna_pkg::OUT_DATA_W - 3 - 2 * NW){1'b0}},
                     out_minor, out_major, out_status};

endmodule

### sv/two_level_device_number_allocator.sv
`timescale 1ns / 1ps
// Allocates and releases (major, minor) device number pairs over a 256 x 256
// space, one request per transfer and one result per request. After reset the
// block runs a clearing pass over the minor bitmap memory and holds
// s_axis_tready low until it ends. A static request steps through accept,
// bitmap read, evaluate and result; a request with a bad parameter goes
// straight from accept to result. A dynamic major first scans the 64-major
// words, top word first, and a dynamic minor repeats the read and evaluate
// steps for each further 64-minor word, since the minor bitmap memory has one
// read port and a registered read. The result step repeats while the previous
// result is still unaccepted. A new request is taken while the previous result
// still waits on the output.
module two_level_device_number_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [7:0] major_request, [15:8] minor_request
  input  logic [tldna_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] operation
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] status, [10:3] major_assigned, [18:11] minor_assigned, [23:19] zero
  output logic [tldna_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  `include "two_level_device_number_allocator_assert.svh"

  tldna_pkg::cmd_t cmd;
  tldna_pkg::sts_t sts;

  tldna_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .sts      (sts),
    .in_ready (s_axis_tready),
    .cmd      (cmd)
  );

  tldna_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (s_axis_tuser),
    .in_major  (s_axis_tdata[7:0]),
    .in_minor  (s_axis_tdata[15:8]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

  `TLDNA_ASSERT_IMP(a_no_accept_in_clear, clk, rst, cmd.clear_step, !s_axis_tready)
  `TLDNA_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.load_out, !m_axis_tvalid || m_axis_tready)
  `TLDNA_ASSERT_IMP(a_fail_zero, clk, rst, m_axis_tvalid && (m_axis_tdata[2:0] != tldna_pkg::STAT_OK), m_axis_tdata[18:3] == '0)
  `TLDNA_ASSERT_NXT(a_load_shows, clk, rst, cmd.load_out, m_axis_tvalid)

endmodule
